FILE: rtl/bb3_pkg.sv
`default_nettype none

package bb3_pkg;

    // fixed field widths
    localparam int PIX_W      = 8;
    localparam int NUM_CH     = 3;
    localparam int OUT_ROW_W  = 12;
    localparam int OUT_COL_W  = 10;
    localparam int REG_WID_W  = 11;
    localparam int REG_HGT_W  = 13;
    localparam int CFG_DATA_W = 13;

    // column sum of up to three pixels of one channel
    localparam int CSUM_W = 10;

    // dimensions after reset and default bounds
    localparam int RESET_WIDTH     = 640;
    localparam int RESET_HEIGHT    = 480;
    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_MAX_HEIGHT  = 4096;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

    // channel order: red, green, blue
    typedef logic [0:NUM_CH-1][PIX_W-1:0] t_pixel;

    // one window column, rows top to bottom
    typedef struct packed {
        t_pixel top;
        t_pixel mid;
        t_pixel bot;
    } t_column;

    // which upper rows of a column are inside the frame
    typedef struct packed {
        logic use_top;
        logic use_mid;
    } t_row_flags;

    // column sums for the upper and the lower output row
    typedef struct packed {
        logic [0:NUM_CH-1][CSUM_W-1:0] up;
        logic [0:NUM_CH-1][CSUM_W-1:0] low;
    } t_col_sum;

endpackage

`default_nettype wire

FILE: rtl/bb3_pix_if.sv
`default_nettype none

interface bb3_pix_if;
    import bb3_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] in_red;
    logic [PIX_W-1:0] in_green;
    logic [PIX_W-1:0] in_blue;

    modport source (output valid, output in_red, output in_green, output in_blue, input ready);
    modport sink   (input valid, input in_red, input in_green, input in_blue, output ready);
endinterface

`default_nettype wire

FILE: rtl/bb3_res_if.sv
`default_nettype none

interface bb3_res_if;
    import bb3_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [PIX_W-1:0]     out_red;
    logic [PIX_W-1:0]     out_green;
    logic [PIX_W-1:0]     out_blue;
    logic [OUT_ROW_W-1:0] out_row;
    logic [OUT_COL_W-1:0] out_col;
    logic                 run_last;

    modport source (
        output valid, output out_red, output out_green, output out_blue,
        output out_row, output out_col, output run_last, input ready
    );
    modport sink (
        input valid, input out_red, input out_green, input out_blue,
        input out_row, input out_col, input run_last, output ready
    );
endinterface

`default_nettype wire

FILE: rtl/bb3_col_cell.sv
`default_nettype none

module bb3_col_cell (
    input  wire logic                i_clk,
    input  wire logic                i_shift,
    input  wire bb3_pkg::t_row_flags i_rows,
    input  wire bb3_pkg::t_column    i_col,
    output bb3_pkg::t_column         o_col,
    output bb3_pkg::t_col_sum        o_sum
);
    import bb3_pkg::*;

    t_column  r_col;
    t_col_sum r_sum;
    t_col_sum n_sum;

    // take the neighbour's column when the window moves on
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
    end

    // per channel sums over the rows inside the frame
    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            n_sum.up[ch]  = (i_rows.use_top ? CSUM_W'(r_col.top[ch]) : CSUM_W'(0))
                          + CSUM_W'(r_col.mid[ch]) + CSUM_W'(r_col.bot[ch]);
            n_sum.low[ch] = (i_rows.use_mid ? CSUM_W'(r_col.mid[ch]) : CSUM_W'(0))
                          + CSUM_W'(r_col.bot[ch]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
    end

    assign o_col = r_col;
    assign o_sum = r_sum;
endmodule

`default_nettype wire

FILE: rtl/box_blur_three_by_three_core.sv
`default_nettype none

// channel   dir  handshake          payload
// i_pix     in   valid / ready      in_red, in_green, in_blue
// o_res     out  valid / ready      out_red, out_green, out_blue, out_row, out_col, run_last
// i_cfg_*   in   write enable only  index 0 image_width, index 1 image_height
//
// an item passes the row store read, the column sum stage and, for each result it
// gives (0 to 4), the shared sum/divide pair
// results leave through one output register; the next item is taken while the
// last result of the previous one still waits there
// output stalls hold the sequencer in its divide step
// synchronous active-low reset clears control state; row stores are not cleared

module box_blur_three_by_three_core #(
    parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    bb3_pix_if.sink                               i_pix,
    bb3_res_if.source                             o_res,
    input  wire logic                             i_cfg_we,
    input  wire bb3_pkg::t_reg_idx                i_cfg_idx,
    input  wire logic [bb3_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import bb3_pkg::*;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int SUM_W   = 12;
    localparam int X_W     = 13;
    localparam int RECIP_K = 16;
    localparam int RECIP_W = 16;
    localparam int PROD_W  = X_W + RECIP_W;
    localparam int NUM_K   = 4;

    localparam int RST_WM1 = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH - 1 : RESET_WIDTH - 1;
    localparam int RST_HM1 = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT - 1 : RESET_HEIGHT - 1;

    // result kinds in emission order
    localparam int K_UP_MID   = 0;
    localparam int K_UP_EDGE  = 1;
    localparam int K_LOW_MID  = 2;
    localparam int K_LOW_EDGE = 3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_COLS,
        S_SUM,
        S_MUL
    } t_state;

    // 2*count reciprocal scaled by 2^16, rounded up; exact over the sum range
    function automatic logic [RECIP_W-1:0] f_recip(input logic [3:0] n);
        logic [RECIP_W-1:0] m;
        case (n)
            4'd1:    m = 16'd32768;
            4'd2:    m = 16'd16384;
            4'd3:    m = 16'd10923;
            4'd4:    m = 16'd8192;
            4'd6:    m = 16'd5462;
            4'd9:    m = 16'd3641;
            default: m = 16'd0;
        endcase
        return m;
    endfunction

    t_state             r_state;
    logic [COL_W-1:0]   r_wm1;
    logic [ROW_W-1:0]   r_hm1;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [NUM_K-1:0]   r_pend;
    t_pixel             r_pix;
    t_pixel             r_older_rd;
    t_pixel             r_newer_rd;
    logic [0:NUM_CH-1][X_W-1:0] r_x;
    logic [RECIP_W-1:0] r_m;
    logic [ROW_W-1:0]   r_orow;
    logic [COL_W-1:0]   r_ocol;
    logic               r_last;
    logic               r_out_valid;
    t_pixel             r_out_px;
    logic [ROW_W-1:0]   r_out_row;
    logic [COL_W-1:0]   r_out_col;
    logic               r_out_last;

    t_pixel r_older_mem [MAX_WIDTH];
    t_pixel r_newer_mem [MAX_WIDTH];

    logic               w_accept;
    logic               w_out_free;
    logic               w_commit;
    logic               w_c_ge1;
    logic               w_c_ge2;
    logic               w_r_ge1;
    logic               w_r_ge2;
    logic               w_last_col;
    logic               w_last_row;
    t_row_flags         w_rows;
    t_column            w_cur_col;
    t_column            w_col_c1;
    t_column            w_col_c0;
    t_col_sum           w_csum [3];
    logic [NUM_K-1:0]   n_pend;
    logic [NUM_K-1:0]   w_kind;
    logic               w_is_low;
    logic               w_is_edge;
    logic               w_use0;
    logic               w_use1;
    logic [1:0]         w_ncols;
    logic [1:0]         w_nrows;
    logic [3:0]         w_n;
    logic [0:NUM_CH-1][X_W-1:0] n_x;
    logic [0:NUM_CH-1][PROD_W-1:0] w_prod;
    t_pixel             w_q;
    logic [COL_W-1:0]   n_wm1;
    logic [ROW_W-1:0]   n_hm1;
    logic [REG_WID_W-1:0] w_cfg_wid;
    logic [REG_HGT_W-1:0] w_cfg_hgt;

    // handshake and position flags
    assign w_accept   = i_pix.valid && i_pix.ready;
    assign i_pix.ready = (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_c_ge1    = (r_col != '0);
    assign w_c_ge2    = (r_col > COL_W'(1));
    assign w_r_ge1    = (r_row != '0);
    assign w_r_ge2    = (r_row > ROW_W'(1));
    assign w_last_col = (r_col == r_wm1);
    assign w_last_row = (r_row == r_hm1);
    assign w_rows     = '{use_top: w_r_ge2, use_mid: w_r_ge1};
    assign w_commit   = (r_state == S_COLS && r_pend == '0)
                     || (r_state == S_MUL && w_out_free && r_last);

    // register values clipped into 1..max
    always_comb begin
        w_cfg_wid = i_cfg_data[REG_WID_W-1:0];
        w_cfg_hgt = i_cfg_data[REG_HGT_W-1:0];
        if (w_cfg_wid == '0) begin
            n_wm1 = '0;
        end else if (int'(w_cfg_wid) > MAX_WIDTH) begin
            n_wm1 = COL_W'(MAX_WIDTH - 1);
        end else begin
            n_wm1 = COL_W'(w_cfg_wid - 1'b1);
        end
        if (w_cfg_hgt == '0) begin
            n_hm1 = '0;
        end else if (int'(w_cfg_hgt) > MAX_HEIGHT) begin
            n_hm1 = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            n_hm1 = ROW_W'(w_cfg_hgt - 1'b1);
        end
    end

    // row stores: read on accept, written when the item retires
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_older_rd <= r_older_mem[r_col];
            r_newer_rd <= r_newer_mem[r_col];
        end
        if (w_commit) begin
            r_older_mem[r_col] <= w_cur_col.mid;
            r_newer_mem[r_col] <= w_cur_col.bot;
        end
    end

    // window chain: column c-2, column c-1, current column
    assign w_cur_col = '{top: r_older_rd, mid: r_newer_rd, bot: r_pix};

    bb3_col_cell u_cell_c2 (
        .i_clk   (i_clk),
        .i_shift (r_state == S_LOAD),
        .i_rows  (w_rows),
        .i_col   (w_col_c1),
        .o_col   (),
        .o_sum   (w_csum[0])
    );

    bb3_col_cell u_cell_c1 (
        .i_clk   (i_clk),
        .i_shift (r_state == S_LOAD),
        .i_rows  (w_rows),
        .i_col   (w_col_c0),
        .o_col   (w_col_c1),
        .o_sum   (w_csum[1])
    );

    bb3_col_cell u_cell_c0 (
        .i_clk   (i_clk),
        .i_shift (r_state == S_LOAD),
        .i_rows  (w_rows),
        .i_col   (w_cur_col),
        .o_col   (w_col_c0),
        .o_sum   (w_csum[2])
    );

    // results this item gives
    always_comb begin
        n_pend             = '0;
        n_pend[K_UP_MID]   = w_r_ge1 && w_c_ge1;
        n_pend[K_UP_EDGE]  = w_r_ge1 && w_last_col;
        n_pend[K_LOW_MID]  = w_last_row && w_c_ge1;
        n_pend[K_LOW_EDGE] = w_last_row && w_last_col;
    end

    // window sum and divisor of the next pending result
    always_comb begin
        w_kind    = r_pend & (~r_pend + NUM_K'(1));
        w_is_low  = w_kind[K_LOW_MID] || w_kind[K_LOW_EDGE];
        w_is_edge = w_kind[K_UP_EDGE] || w_kind[K_LOW_EDGE];
        w_use0    = !w_is_edge && w_c_ge2;
        w_use1    = !(w_is_edge && !w_c_ge1);
        w_ncols   = 2'd1 + 2'(w_use0) + 2'(w_use1);
        w_nrows   = w_is_low ? (w_r_ge1 ? 2'd2 : 2'd1) : (w_r_ge2 ? 2'd3 : 2'd2);
        w_n       = 4'(w_ncols) * 4'(w_nrows);
        for (int ch = 0; ch < NUM_CH; ch++) begin
            logic [SUM_W-1:0] s0, s1, s2;
            s0 = w_use0 ? SUM_W'(w_is_low ? w_csum[0].low[ch] : w_csum[0].up[ch])
                        : SUM_W'(0);
            s1 = w_use1 ? SUM_W'(w_is_low ? w_csum[1].low[ch] : w_csum[1].up[ch])
                        : SUM_W'(0);
            s2 = SUM_W'(w_is_low ? w_csum[2].low[ch] : w_csum[2].up[ch]);
            n_x[ch] = {s0 + s1 + s2, 1'b0} + X_W'(w_n);
        end
    end

    // rounded mean by reciprocal multiply
    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            w_prod[ch] = PROD_W'(r_x[ch]) * PROD_W'(r_m);
            w_q[ch]    = w_prod[ch][RECIP_K+PIX_W-1:RECIP_K];
        end
    end

    // sequencer, positions, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wm1       <= COL_W'(RST_WM1);
            r_hm1       <= ROW_W'(RST_HM1);
            r_col       <= '0;
            r_row       <= '0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // result register: loaded by the divide step, cleared when taken
            if (r_state == S_MUL && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_pix   <= {i_pix.in_red, i_pix.in_green, i_pix.in_blue};
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_pend  <= n_pend;
                    r_state <= S_COLS;
                end
                S_COLS: begin
                    r_state <= (r_pend == '0) ? S_IDLE : S_SUM;
                end
                S_SUM: begin
                    r_x     <= n_x;
                    r_m     <= f_recip(w_n);
                    r_orow  <= w_is_low ? r_row : r_row - 1'b1;
                    r_ocol  <= w_is_edge ? r_col : r_col - 1'b1;
                    r_last  <= ((r_pend & ~w_kind) == '0);
                    r_pend  <= r_pend & ~w_kind;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (w_out_free) begin
                        r_out_px    <= w_q;
                        r_out_row   <= r_orow;
                        r_out_col   <= r_ocol;
                        r_out_last  <= r_last;
                        r_state     <= r_last ? S_IDLE : S_SUM;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // step to the next raster position when an item retires
            if (w_commit && !i_cfg_we) begin
                if (w_last_col) begin
                    r_col <= '0;
                    r_row <= w_last_row ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            // a register write restarts the frame
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_IMAGE_WIDTH: begin
                        r_wm1 <= n_wm1;
                        r_col <= '0;
                        r_row <= '0;
                    end
                    REG_IMAGE_HEIGHT: begin
                        r_hm1 <= n_hm1;
                        r_col <= '0;
                        r_row <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.out_red   = r_out_px[0];
    assign o_res.out_green = r_out_px[1];
    assign o_res.out_blue  = r_out_px[2];
    assign o_res.out_row   = OUT_ROW_W'(r_out_row);
    assign o_res.out_col   = OUT_COL_W'(r_out_col);
    assign o_res.run_last  = r_out_last;

    // a new item only starts once every result of the last one is issued
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> (r_pend == '0))
        else $error("item accepted with results still pending");

    // the sum step always has a result to work on
    a_sum_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) |-> (r_pend != '0))
        else $error("sum step with no pending result");

    // a waiting result holds still until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> (o_res.valid && $stable(r_out_px)
            && $stable(r_out_row) && $stable(r_out_col) && $stable(r_out_last)))
        else $error("waiting result changed before it was taken");

endmodule

`default_nettype wire
